// ----- hdl/fdbq_pkg.sv -----
// Package: constants and helpers for the bf16-quantising single-precision divider.
package fdbq_pkg;

  localparam int unsigned NumSteps   = 32;
  localparam int unsigned StepsPerSt = 4;
  localparam int unsigned NumDivSt   = NumSteps / StepsPerSt;

  localparam logic [31:0] PosInf  = 32'h7f80_0000;
  localparam logic [31:0] MagMask = 32'h7fff_ffff;
  localparam logic [31:0] SeMask  = 32'hff80_0000;
  localparam logic [31:0] Bias    = 32'h3f80_0000;

  // Round to bfloat16 (nearest even) and widen back; quieten NaNs.
  function automatic logic [31:0] bf16_round_trip(input logic [31:0] x);
    logic [31:0] sum;
    logic [15:0] h;
    begin
      sum = x + 32'h0000_7fff + {31'd0, x[16]};
      if ((x & MagMask) > PosInf) begin
        h = x[31:16] | 16'h0040;
      end else begin
        h = sum[31:16];
      end
      return {h, 16'h0000};
    end
  endfunction

endpackage

// ----- hdl/fp32_divider_bf16_quantize_core.sv -----
// Top level: pipelined single-precision divider with optional bf16 input rounding.
// Pipeline: ten register stages: one operand stage, eight mantissa stages of four
// restoring steps each, and the output register fed by the packing logic.
// Throughput: one request per cycle; a stall at the output freezes the whole pipe.
// Reset: rst_ni asynchronous active low clears the stage valid bits and the
// quantize register; payload registers are not reset.
module fp32_divider_bf16_quantize_core import fdbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        quantize_inputs_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] dividend_bits_i,
  input  logic [31:0] divisor_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] quotient_bits_o
);

  localparam int unsigned NumSt = NumDivSt + 2;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [32:0] rem;   // partial remainder, wide enough for doubled values
    logic [31:0] q;
  } stage_t;

  logic              quant_q;
  logic [NumSt-1:0]  vld_q;
  stage_t            st_q [NumDivSt+1];
  logic [31:0]       res_d;
  logic              adv;
  logic [31:0]       a_in;
  logic [31:0]       b_in;

  // Advance everything when the output slot is free or being drained.
  assign adv         = !vld_q[NumSt-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q <= 1'b0;
    end else if (cfg_valid_i) begin
      quant_q <= quantize_inputs_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumSt-2:0], in_valid_i};
    end
  end

  // Operand stage: optional quantisation, seed the mantissa divider.
  assign a_in = quant_q ? bf16_round_trip(dividend_bits_i) : dividend_bits_i;
  assign b_in = quant_q ? bf16_round_trip(divisor_bits_i) : divisor_bits_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].a   <= a_in;
      st_q[0].b   <= b_in;
      st_q[0].rem <= {9'd0, 1'b1, a_in[22:0]};
      st_q[0].q   <= '0;
    end
  end

  // Restoring division stages, four steps per stage.
  for (genvar s = 1; s <= NumDivSt; s++) begin : g_div
    stage_t nxt;
    always_comb begin
      logic [32:0] den;
      nxt = st_q[s-1];
      den = {9'd0, 1'b1, nxt.b[22:0]};
      for (int k = 0; k < StepsPerSt; k++) begin
        nxt.q = {nxt.q[30:0], 1'b0};
        if (nxt.rem >= den) begin
          nxt.q[0] = 1'b1;
          nxt.rem  = nxt.rem - den;
        end
        nxt.rem = {nxt.rem[31:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[s] <= nxt;
      end
    end
  end

  // Pack sign/exponent and mantissa, apply special cases.
  always_comb begin
    stage_t      p;
    logic        shift;
    logic [31:0] qn;
    logic [31:0] r;
    p     = st_q[NumDivSt];
    shift = !p.q[31];
    qn    = shift ? {p.q[30:0], 1'b0} : p.q;
    r     = (p.a & SeMask) - (p.b & SeMask) + Bias - (shift ? 32'h0080_0000 : 32'd0);
    r     = r | ((qn & 32'h7fff_ff00) >> 8);
    if ((p.a[31] ^ p.b[31]) != r[31]) begin
      r = PosInf;
    end
    if ((p.a & MagMask) == 32'd0) begin
      res_d = p.a;
    end else if ((p.b & MagMask) == 32'd0) begin
      res_d = PosInf;
    end else begin
      res_d = r;
    end
  end

  logic [31:0] out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o     = vld_q[NumSt-1];
  assign quotient_bits_o = out_q;

  // The output register only changes while it is free or drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quotient_bits_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule

// ----- tb/testbench.sv -----
// Testbench for the pipelined single-precision divider with optional bf16 input rounding.
`timescale 1ns / 1ps

module testbench;
  import fdbq_pkg::*;

  localparam int unsigned Latency    = 10;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        quantize_inputs_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] dividend_bits_i;
  logic [31:0] divisor_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] quotient_bits_o;

  // Predictor copy of the mode register, updated when a write is accepted.
  logic        quantize_mode;
  logic [31:0] quotient_queue[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  // Receiver behaviour controls.
  bit          rx_idle_enable;
  bit          rx_hold_request;

  fp32_divider_bf16_quantize_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .quantize_inputs_i(quantize_inputs_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .dividend_bits_i  (dividend_bits_i),
    .divisor_bits_i   (divisor_bits_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .quotient_bits_o  (quotient_bits_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Round an operand to bfloat16 and widen it; NaNs are truncated and quietened.
  function automatic logic [31:0] round_to_bf16(input logic [31:0] x);
    logic [31:0] widened;
    if ((x & 32'h7fff_ffff) > 32'h7f80_0000) begin
      widened = {x[31:16] | 16'h0040, 16'h0000};
    end else begin
      widened = x + 32'h0000_7fff + {31'd0, x[16]};
      widened = {widened[31:16], 16'h0000};
    end
    return widened;
  endfunction

  // Divide two bit patterns the way the hardware does: restoring mantissa
  // division, one-bit normalise, truncate, sign check forcing +infinity.
  function automatic logic [31:0] divide_patterns(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] q;
    logic [31:0] packed_res;
    logic        norm_shift;
    if (a[30:0] == 31'd0) return a;
    if (b[30:0] == 31'd0) return 32'h7f80_0000;
    num = {8'd0, 1'b1, a[22:0]};
    den = {8'd0, 1'b1, b[22:0]};
    q   = '0;
    for (int i = 0; i < 32; i++) begin
      q = q << 1;
      if (num >= den) begin
        q[0] = 1'b1;
        num  = num - den;
      end
      num = num << 1;
    end
    norm_shift = ~q[31];
    if (norm_shift) q = q << 1;
    packed_res = (a & 32'hff80_0000) - (b & 32'hff80_0000) + 32'h3f80_0000;
    if (norm_shift) packed_res = packed_res - 32'h0080_0000;
    packed_res = packed_res | ((q & 32'h7fff_ff00) >> 8);
    if (a[31] ^ b[31] ^ packed_res[31]) packed_res = 32'h7f80_0000;
    return packed_res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h expected %08h at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // Offer one request, with an optional random gap first; hold until accepted.
  // Valid stays high after acceptance so back-to-back requests follow with no gap;
  // drop it before a gap and when the sender stops.
  task automatic send_division(input logic [31:0] dividend, input logic [31:0] divisor,
                               input bit allow_gap);
    logic [31:0] a;
    logic [31:0] b;
    if (allow_gap && ($urandom_range(0, 7) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    dividend_bits_i <= dividend;
    divisor_bits_i  <= divisor;
    do @(posedge clk_i); while (!in_ready_o);
    a = quantize_mode ? round_to_bf16(dividend) : dividend;
    b = quantize_mode ? round_to_bf16(divisor) : divisor;
    quotient_queue.push_back(divide_patterns(a, b));
  endtask

  // Wait for every outstanding quotient, then let the pipe drain fully.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (quotient_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    drain_pipe();
    cfg_valid_i       <= 1'b1;
    quantize_inputs_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    quantize_mode = mode;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0: x[30:0] = 31'd0;
      1: x[30:23] = 8'hff;
      2: x[30:23] = 8'h00;
      3: x[15:0] = 16'h8000;
      4: x[15:0] = {$urandom_range(0, 1) ? 16'h7fff : 16'h8001};
      5: x[30:23] = $urandom_range(0, 1) ? 8'hfe : 8'h01;
      default: x[30:23] = 8'($urandom_range(100, 154));
    endcase
    return x;
  endfunction

  // Extremes and special cases: zeros, zero divisor, both zero, infinities,
  // NaNs, subnormals, overflow and underflow, rounding ties.
  task automatic test_directed(input logic mode);
    logic [31:0] edge_vals[20];
    write_mode(mode);
    edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                  32'h7f7f_ffff, 32'h0080_0000, 32'h0000_0001, 32'h807f_ffff,
                  32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h7f80_0001,
                  32'hffff_ffff, 32'h3f80_8000, 32'h3f81_8000, 32'h4049_0fdb,
                  32'h7f7f_8000, 32'h3fff_ffff, 32'h4000_0000, 32'hc0a0_0000};
    for (int i = 0; i < 20; i++) begin
      send_division(edge_vals[i], edge_vals[(i * 7 + 3) % 20], 1'b1);
    end
    send_division(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_division(32'h8000_0000, 32'h3f80_0000, 1'b0);
    send_division(32'h3f80_0000, 32'h8000_0000, 1'b0);
  endtask

  task automatic test_random(input int unsigned count, input bit allow_gap);
    for (int unsigned i = 0; i < count; i++) begin
      send_division(random_float(), random_float(), allow_gap);
    end
  endtask

  // Hold the receiver off long enough to fill the pipe and stall the input.
  task automatic test_backpressure();
    rx_hold_request = 1'b1;
    test_random(60, 1'b0);
    drain_pipe();
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    quantize_inputs_i = 1'b0;
    in_valid_i        = 1'b0;
    dividend_bits_i   = '0;
    divisor_bits_i    = '0;
    quantize_mode     = 1'b0;
    mismatch_count    = 0;
    rx_idle_enable    = 1'b1;
    rx_hold_request   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed(1'b0);
    test_directed(1'b1);
    write_mode(1'b0);
    test_random(500, 1'b1);
    // Pause the sender until every quotient has come back.
    drain_pipe();
    test_backpressure();
    write_mode(1'b1);
    test_random(500, 1'b1);
    write_mode(1'b0);
    test_random(300, 1'b1);
    // Last part: no idling on either side.
    rx_idle_enable = 1'b0;
    write_mode(1'b1);
    test_random(400, 1'b0);

    drain_pipe();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold requested by a test.
  initial begin
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        stall_left = 40;
      end else if (stall_left == 0 && rx_idle_enable && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check every accepted quotient against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quotient_queue.size() == 0) begin
        report_mismatch("unexpected quotient", quotient_bits_o, 32'h0);
      end else begin
        logic [31:0] want;
        want = quotient_queue.pop_front();
        if (quotient_bits_o !== want) report_mismatch("quotient_bits", quotient_bits_o, want);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

// ----- fp32_divider_bf16_quantize_core.f -----
hdl/fdbq_pkg.sv
hdl/fp32_divider_bf16_quantize_core.sv
tb/testbench.sv
